FILE: src/rmms_pkg.sv
`default_nettype none
package rmms_pkg;

    localparam int GRADE_W    = 8;
    localparam int DEV_W      = 16;
    localparam int DIV_QW     = 30;
    localparam int DIV_IW     = 5;
    localparam int DEV_FRAC   = 16;
    localparam int DEV_SHIFT  = DIV_QW - DEV_FRAC;
    localparam int MUL_CW     = 4;

    typedef logic [GRADE_W-1:0] t_grade;
    typedef logic [DEV_W-1:0]   t_dev;
    typedef logic [DIV_QW-1:0]  t_quot;
    typedef logic [DIV_IW-1:0]  t_iter;

    localparam t_iter MEAN_ITERS = t_iter'(GRADE_W);
    localparam t_iter DEV_ITERS  = t_iter'(DIV_QW);
    localparam t_quot SQRT_TOP   = t_quot'(1) << (DIV_QW - 2);

endpackage
`default_nettype wire

FILE: src/rmms_in_if.sv
`default_nettype none
interface rmms_in_if;
    import rmms_pkg::*;

    logic   valid;
    logic   ready;
    t_grade grade;

    modport source (output valid, output grade, input ready);
    modport sink (input valid, input grade, output ready);
endinterface
`default_nettype wire

FILE: src/rmms_out_if.sv
`default_nettype none
interface rmms_out_if;
    import rmms_pkg::*;

    logic   valid;
    logic   ready;
    t_grade entry_count;
    t_grade lowest;
    t_grade highest;
    t_grade average;
    t_dev   deviation;
    logic   refused;

    modport source (output valid, output entry_count, output lowest, output highest,
                    output average, output deviation, output refused, input ready);
    modport sink (input valid, input entry_count, input lowest, input highest,
                  input average, input deviation, input refused, output ready);
endinterface
`default_nettype wire

FILE: src/rmms_div.sv
`default_nettype none
module rmms_div #(
    parameter int NW = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NW-1:0]    i_divisor,
    input  wire logic [NW-1:0]    i_rem_init,
    input  wire rmms_pkg::t_quot  i_bits,
    input  wire rmms_pkg::t_iter  i_iters,
    output logic                  o_done,
    output rmms_pkg::t_quot       o_quot,
    output logic [NW-1:0]         o_rem
);
    import rmms_pkg::*;

    logic [NW-1:0] r_rem;
    logic [NW-1:0] n_rem;
    t_quot         r_bits;
    t_quot         r_quot;
    t_iter         r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [NW:0]   w_trial;
    logic [NW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_trial = {r_rem, r_bits[DIV_QW-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_ge    = w_trial >= {1'b0, i_divisor};
        n_rem   = w_ge ? w_diff[NW-1:0] : w_trial[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - t_iter'(1);
                if (r_cnt == t_iter'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem_init;
            r_bits <= i_bits;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= r_bits << 1;
            r_quot <= {r_quot[DIV_QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

FILE: src/rmms_mul.sv
`default_nettype none
module rmms_mul #(
    parameter int MW = 16,
    parameter int AW = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [AW-1:0]    i_minuend,
    input  wire logic [MW-1:0]    i_mcand,
    input  wire rmms_pkg::t_grade i_mult,
    output logic                  o_done,
    output logic [AW-1:0]         o_diff
);
    import rmms_pkg::*;

    logic [AW-1:0]     r_acc;
    logic [AW-1:0]     r_mc;
    t_grade            r_m;
    logic [MUL_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CW'(GRADE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_CW'(1);
                if (r_cnt == MUL_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_minuend;
            r_mc  <= AW'(i_mcand);
            r_m   <= i_mult;
        end else if (r_busy) begin
            if (r_m[0]) begin
                r_acc <= r_acc - r_mc;
            end
            r_mc <= r_mc << 1;
            r_m  <= r_m >> 1;
        end
    end

    assign o_done = r_done;
    assign o_diff = r_acc;
endmodule
`default_nettype wire

FILE: src/rmms_sqrt.sv
`default_nettype none
module rmms_sqrt (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire rmms_pkg::t_quot i_radicand,
    output logic                 o_done,
    output rmms_pkg::t_dev       o_root
);
    import rmms_pkg::*;

    t_quot           r_x;
    t_quot           r_root;
    t_quot           r_bit;
    logic            r_busy;
    logic            r_done;
    logic [DIV_QW:0] w_sum;
    logic            w_ge;

    always_comb begin
        w_sum = {1'b0, r_root} + {1'b0, r_bit};
        w_ge  = {1'b0, r_x} >= w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_root <= '0;
            r_bit  <= SQRT_TOP;
        end else if (r_busy) begin
            if (w_ge) begin
                r_x    <= r_x - w_sum[DIV_QW-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[DEV_W-1:0];
endmodule
`default_nettype wire

FILE: src/running_min_max_mean_stddev_core.sv
// Running grade statistics: count, minimum, maximum, truncated mean and the
// population standard deviation about that mean, UQ8.8, rounded down.
// i_in carries one grade per transaction; o_out carries one result per grade.
// A grade is taken only while the core is idle. After it, the core runs a
// shared restoring divider for the mean, a shift-and-subtract multiplier
// for the centered sum of squares, the same divider for the scaled
// variance and a bit-pair square root, then loads the result register.
// The core returns to idle in the cycle after that load, so it takes no
// new grade until the result for the last one is loaded.
// Once MAX_ENTRIES grades are held, further grades are refused and flagged,
// and the result reports the statistics already held.
// o_out holds its result until taken; a stalled receiver blocks only the
// loading of the following result, so one more grade can be in work.
// Reset clears all statistics to zero and drops any pending result.
`default_nettype none
module running_min_max_mean_stddev_core #(
    parameter int MAX_ENTRIES = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rmms_in_if.sink    i_in,
    rmms_out_if.source o_out
);
    import rmms_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = CW + GRADE_W;
    localparam int QW = CW + 2 * GRADE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MEAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DEV  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_count;
    t_grade        r_min;
    t_grade        r_max;
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sq;
    logic          r_refuse;
    t_grade        r_mean;
    t_dev          r_dev;
    logic          r_out_valid;
    t_grade        r_o_count;
    t_grade        r_o_min;
    t_grade        r_o_max;
    t_grade        r_o_mean;
    t_dev          r_o_dev;
    logic          r_o_refuse;

    logic                  w_accept;
    logic                  w_full;
    logic [2*GRADE_W-1:0]  w_gsq;
    logic                  w_load_out;

    logic          w_div_start;
    logic [CW-1:0] w_div_init;
    t_quot         w_div_bits;
    t_iter         w_div_iters;
    logic          w_div_done;
    t_quot         w_div_quot;
    logic [CW-1:0] w_div_rem;

    logic          w_mul_start;
    logic          w_mul_done;
    logic [QW-1:0] w_mul_diff;
    logic [SW-1:0] w_mcand;
    logic [QW-1:0] w_t_hi;

    logic          w_sqrt_start;
    logic          w_sqrt_done;
    t_dev          w_sqrt_root;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = r_count >= CW'(MAX_ENTRIES);
    assign w_gsq      = {{GRADE_W{1'b0}}, i_in.grade} * {{GRADE_W{1'b0}}, i_in.grade};
    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign w_mcand    = r_sum + SW'(w_div_rem);
    assign w_t_hi     = w_mul_diff >> DEV_SHIFT;

    always_comb begin
        w_div_start  = 1'b0;
        w_mul_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_div_init   = r_sum[SW-1:GRADE_W];
        w_div_bits   = {r_sum[GRADE_W-1:0], {(DIV_QW-GRADE_W){1'b0}}};
        w_div_iters  = MEAN_ITERS;
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                w_div_start = 1'b1;
                n_state     = S_MEAN;
            end
            S_MEAN: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                w_div_init  = w_t_hi[CW-1:0];
                w_div_bits  = {w_mul_diff[DEV_SHIFT-1:0], {DEV_FRAC{1'b0}}};
                w_div_iters = DEV_ITERS;
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    n_state     = S_DEV;
                end
            end
            S_DEV: begin
                if (w_div_done) begin
                    w_sqrt_start = 1'b1;
                    n_state      = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_refuse    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_refuse <= w_full;
                if (!w_full) begin
                    r_count <= r_count + CW'(1);
                    r_sum   <= r_sum + SW'(i_in.grade);
                    r_sq    <= r_sq + QW'(w_gsq);
                    if (r_count == '0) begin
                        r_min <= i_in.grade;
                        r_max <= i_in.grade;
                    end else begin
                        if (i_in.grade < r_min) begin
                            r_min <= i_in.grade;
                        end
                        if (i_in.grade > r_max) begin
                            r_max <= i_in.grade;
                        end
                    end
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MEAN && w_div_done) begin
            r_mean <= w_div_quot[GRADE_W-1:0];
        end
        if (w_sqrt_done) begin
            r_dev <= w_sqrt_root;
        end
        if (w_load_out) begin
            r_o_count  <= GRADE_W'(r_count);
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_mean   <= r_mean;
            r_o_dev    <= r_dev;
            r_o_refuse <= r_refuse;
        end
    end

    rmms_div #(
        .NW(CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (r_count),
        .i_rem_init (w_div_init),
        .i_bits     (w_div_bits),
        .i_iters    (w_div_iters),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    rmms_mul #(
        .MW(SW),
        .AW(QW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_minuend (r_sq),
        .i_mcand   (w_mcand),
        .i_mult    (w_div_quot[GRADE_W-1:0]),
        .o_done    (w_mul_done),
        .o_diff    (w_mul_diff)
    );

    rmms_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_div_quot),
        .o_done     (w_sqrt_done),
        .o_root     (w_sqrt_root)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.entry_count = r_o_count;
    assign o_out.lowest      = r_o_min;
    assign o_out.highest     = r_o_max;
    assign o_out.average     = r_o_mean;
    assign o_out.deviation   = r_o_dev;
    assign o_out.refused     = r_o_refuse;
endmodule
`default_nettype wire

FILE: tb/sv/tb_running_min_max_mean_stddev_core.sv
module tb_running_min_max_mean_stddev_core;
    import rmms_pkg::*;

    localparam int MAX_ENTRIES   = 128;
    localparam int NUM_DIRECTED  = 22;
    localparam int NUM_ITEMS     = 1200;
    localparam int PHASE_LEN     = 45;
    localparam int LONG_HOLD     = 1500;
    localparam int HOLD_AFTER    = 20;
    localparam int DRAIN_CYCLES  = 150;
    localparam int QUIET_LIMIT   = 20000;

    typedef struct packed {
        t_grade entry_count;
        t_grade lowest;
        t_grade highest;
        t_grade average;
        t_dev   deviation;
        logic   refused;
    } t_stats;

    typedef struct packed {
        t_grade grade;
        logic   checked;
        t_stats want;
    } t_directed_row;

    localparam t_stats NO_CHECK = '0;

    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{8'd255, 1'b1, '{8'd1, 8'd255, 8'd255, 8'd255, 16'd0, 1'b0}},
        '{8'd0,   1'b1, '{8'd2, 8'd0, 8'd255, 8'd127, 16'd32640, 1'b0}},
        '{8'd0,   1'b0, NO_CHECK},
        '{8'd255, 1'b0, NO_CHECK},
        '{8'd1,   1'b0, NO_CHECK},
        '{8'd254, 1'b0, NO_CHECK},
        '{8'd128, 1'b0, NO_CHECK},
        '{8'd127, 1'b0, NO_CHECK},
        '{8'd85,  1'b0, NO_CHECK},
        '{8'd170, 1'b0, NO_CHECK},
        '{8'd15,  1'b0, NO_CHECK},
        '{8'd240, 1'b0, NO_CHECK},
        '{8'd100, 1'b0, NO_CHECK},
        '{8'd100, 1'b0, NO_CHECK},
        '{8'd100, 1'b0, NO_CHECK},
        '{8'd50,  1'b0, NO_CHECK},
        '{8'd75,  1'b0, NO_CHECK},
        '{8'd200, 1'b0, NO_CHECK},
        '{8'd3,   1'b0, NO_CHECK},
        '{8'd17,  1'b0, NO_CHECK},
        '{8'd99,  1'b0, NO_CHECK},
        '{8'd64,  1'b0, NO_CHECK}
    };

    logic i_clk;
    logic i_rst_n;

    rmms_in_if  grade_ch ();
    rmms_out_if stats_ch ();

    running_min_max_mean_stddev_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (grade_ch),
        .o_out  (stats_ch)
    );

    int held_count;
    longint unsigned grade_sum;
    longint unsigned square_sum;
    t_grade low_grade;
    t_grade high_grade;

    t_stats pending_stats[$];
    int grades_taken;
    int results_taken;
    int mismatch_count;
    int source_idle_pct = 28;
    int sink_idle_pct = 73;
    bit long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root = 0;
        longint unsigned probe = 64'h4000_0000_0000_0000;
        while (probe > x) probe >>= 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic t_stats stats_after_grade(t_grade g);
        t_stats r;
        longint unsigned n;
        longint unsigned mean;
        longint unsigned spread;
        r = '0;
        r.refused = (held_count >= MAX_ENTRIES);
        if (!r.refused) begin
            if (held_count == 0) begin
                low_grade  = g;
                high_grade = g;
            end else begin
                if (g < low_grade) low_grade = g;
                if (g > high_grade) high_grade = g;
            end
            held_count++;
            grade_sum  += longint'(g);
            square_sum += longint'(g) * longint'(g);
        end
        if (held_count != 0) begin
            n      = longint'(held_count);
            mean   = grade_sum / n;
            spread = square_sum + n * mean * mean - 2 * mean * grade_sum;
            r.average   = t_grade'(mean);
            r.deviation = t_dev'(floor_sqrt((spread << 16) / n));
        end
        r.entry_count = t_grade'(held_count);
        r.lowest      = low_grade;
        r.highest     = high_grade;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : grade_monitor
        t_stats predicted;
        if (i_rst_n && grade_ch.valid && grade_ch.ready) begin
            predicted = stats_after_grade(grade_ch.grade);
            if (grades_taken < NUM_DIRECTED && DIRECTED[grades_taken].checked)
                predicted = DIRECTED[grades_taken].want;
            pending_stats.push_back(predicted);
            grades_taken++;
        end
    end

    always @(posedge i_clk) begin : stats_monitor
        t_stats want;
        if (i_rst_n && stats_ch.valid && stats_ch.ready) begin
            results_taken++;
            if (pending_stats.size() == 0) begin
                mismatch_count++;
                $error("result transaction with no grade pending");
            end else begin
                want = pending_stats.pop_front();
                check_field("entry_count", want.entry_count, stats_ch.entry_count);
                check_field("lowest", want.lowest, stats_ch.lowest);
                check_field("highest", want.highest, stats_ch.highest);
                check_field("average", want.average, stats_ch.average);
                check_field("deviation", want.deviation, stats_ch.deviation);
                check_field("refused", want.refused, stats_ch.refused);
            end
        end
    end

    initial begin : receiver
        stats_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_taken >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stats_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stats_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((grade_ch.valid && grade_ch.ready) || (stats_ch.valid && stats_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("running_min_max_mean_stddev_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_grade g;
        int pick;
        int gap;
        i_rst_n        <= 1'b0;
        grade_ch.valid <= 1'b0;
        grade_ch.grade <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int item = 0; item < NUM_ITEMS; item++) begin
            case ((item / PHASE_LEN) % 3)
                0: begin
                    source_idle_pct = 28;
                    sink_idle_pct   = 73;
                end
                1: begin
                    source_idle_pct = 73;
                    sink_idle_pct   = 28;
                end
                default: begin
                    source_idle_pct = 0;
                    sink_idle_pct   = 0;
                end
            endcase
            if (item < NUM_DIRECTED) begin
                g = DIRECTED[item].grade;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    g = t_grade'($urandom_range(0, 100));
                else if (pick < 85)
                    g = ($urandom_range(0, 1) != 0) ? 8'hFF - t_grade'($urandom_range(0, 1))
                                                    : t_grade'($urandom_range(0, 1));
                else
                    g = t_grade'($urandom);
            end
            gap = 0;
            while ($urandom_range(0, 99) < source_idle_pct) gap++;
            if (gap != 0) begin
                grade_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            grade_ch.valid <= 1'b1;
            grade_ch.grade <= g;
            @(posedge i_clk);
            while (!grade_ch.ready) @(posedge i_clk);
        end
        grade_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_stats.size() != 0) begin
            mismatch_count++;
            $error("%0d expected results never arrived", pending_stats.size());
        end
        if (mismatch_count == 0)
            $display("running_min_max_mean_stddev_core regression: pass");
        else
            $display("running_min_max_mean_stddev_core regression: fail");
        $finish;
    end

endmodule
